// ===== design/m4inv_pkg.sv =====
// Shared constants, types and index tables for the 4x4 cofactor inverse.
package m4inv_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // terms 3..5 of a 3x3 determinant are subtracted
    localparam logic [2:0] NEG_TERM_FIRST = 3'd3;
    localparam logic [2:0] LAST_TERM      = 3'd5;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_sts;

    // minor position (0..8) of operand slot in one of the six 3x3 terms
    function automatic logic [3:0] f_term_pos(input logic [2:0] term, input logic [1:0] slot);
        logic [11:0] trip;
        begin
            unique case (term)
                3'd0:    trip = {4'd0, 4'd4, 4'd8};
                3'd1:    trip = {4'd1, 4'd5, 4'd6};
                3'd2:    trip = {4'd2, 4'd3, 4'd7};
                3'd3:    trip = {4'd2, 4'd4, 4'd6};
                3'd4:    trip = {4'd1, 4'd3, 4'd8};
                3'd5:    trip = {4'd0, 4'd5, 4'd7};
                default: trip = '0;
            endcase
            unique case (slot)
                2'd0:    f_term_pos = trip[11:8];
                2'd1:    f_term_pos = trip[7:4];
                default: f_term_pos = trip[3:0];
            endcase
        end
    endfunction

    // matrix address of minor element m for the cofactor at (row, col)
    function automatic logic [3:0] f_minor_addr(input logic [1:0] row, input logic [1:0] col,
                                                input logic [3:0] m);
        logic [1:0] mi;
        logic [3:0] mj;
        logic [1:0] ri;
        logic [1:0] cj;
        begin
            mi = (m >= 4'd6) ? 2'd2 : ((m >= 4'd3) ? 2'd1 : 2'd0);
            mj = m - 4'(mi) * 4'd3;
            ri = mi + ((mi >= row) ? 2'd1 : 2'd0);
            cj = mj[1:0] + ((mj[1:0] >= col) ? 2'd1 : 2'd0);
            f_minor_addr = {ri, cj};
        end
    endfunction

endpackage

// ===== design/m4inv_if.sv =====
// Valid/ready channel interfaces for matrix elements in and inverse elements out.
interface m4inv_in_if #(
    parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface m4inv_out_if #(
    parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [ELEMENT_WIDTH-1:0] result_element;
    logic [3:0]                      result_index;
    logic                            final_res;
    logic                            singular;
    logic                            saturated;

    modport source (output valid, output result_element, output result_index,
                    output final_res, output singular, output saturated, input ready);
    modport sink   (input valid, input result_element, input result_index,
                    input final_res, input singular, input saturated, output ready);
endinterface

// ===== design/m4inv_div.sv =====
// Restoring divider, one quotient bit per cycle, with signed saturation of the quotient.
module m4inv_div #(
    parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF,
    parameter int NUM_W         = 3 * ELEMENT_WIDTH + 3 + 2 * m4inv_pkg::FRAC_BITS_DEF,
    parameter int DEN_W         = 4 * ELEMENT_WIDTH + 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_neg,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [DEN_W-1:0]         i_dmag,
    output logic [ELEMENT_WIDTH-1:0] o_value,
    output m4inv_pkg::t_div_sts      o_sts
);
    import m4inv_pkg::*;

    localparam int W     = ELEMENT_WIDTH;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [W-1:0]     r_q, n_q;
    logic             r_big, n_big;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [W-1:0]     w_lim;
    logic             w_sat;
    logic [W-1:0]     w_mag;

    assign w_rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_dmag});

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_q    = r_q;
        n_big  = r_big;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_q    = '0;
            n_big  = 1'b0;
            n_neg  = i_neg;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            n_rem = w_ge ? (w_rem_sh - {1'b0, i_dmag}) : w_rem_sh;
            n_q   = {r_q[W-2:0], w_ge};
            // a set bit leaving the kept quotient field means overflow
            n_big = r_big | r_q[W-1];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_big <= n_big;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
    end

    assign w_lim      = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign w_sat      = r_big || (r_q > w_lim);
    assign w_mag      = w_sat ? w_lim : r_q;
    assign o_value    = r_neg ? (~w_mag + W'(1)) : w_mag;
    assign o_sts.done = r_done;
    assign o_sts.sat  = w_sat;

endmodule

// ===== design/matrix4_inverse_by_cofactors_top.sv =====
// 4x4 fixed-point matrix inverse: adjugate over determinant with one shared serial multiplier and a divider.
// After the sixteenth input transfer the sixteen cofactors are computed, then the determinant, then each
//   result is divided out (for a singular matrix, taken from the identity) and held until the output takes it.
// Throughput: one matrix at a time, set by the bit-serial multiplier and divider.
// Reset (synchronous, active low) clears the sequencer, load count and output valid.
module matrix4_inverse_by_cofactors_top #(
    parameter int FRAC_BITS     = m4inv_pkg::FRAC_BITS_DEF,
    parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m4inv_in_if.sink    i_elem,
    m4inv_out_if.source o_res
);
    import m4inv_pkg::*;

    localparam int W     = ELEMENT_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int CW    = 3 * W + 3;
    localparam int PW    = CW + W;
    localparam int DW    = 4 * W + 5;
    localparam int NW    = CW + 2 * F;
    localparam int MCW   = $clog2(W + 1);
    localparam logic [W-1:0] ONE_VAL = (F < W - 1) ? (W'(1) << F) : {1'b0, {(W-1){1'b1}}};
    localparam logic         ONE_SAT = (F >= W - 1);

    typedef enum logic [12:0] {
        ST_LOAD   = 13'b0000000000001,
        ST_FETCH  = 13'b0000000000010,
        ST_USE    = 13'b0000000000100,
        ST_MUL    = 13'b0000000001000,
        ST_ACC    = 13'b0000000010000,
        ST_CWR    = 13'b0000000100000,
        ST_CFETCH = 13'b0000001000000,
        ST_CUSE   = 13'b0000010000000,
        ST_DSETUP = 13'b0000100000000,
        ST_DFETCH = 13'b0001000000000,
        ST_DLOAD  = 13'b0010000000000,
        ST_DIV    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_state;

    t_state                r_state, n_state;
    logic [3:0]            r_k, n_k;
    logic [2:0]            r_term, n_term;
    logic [1:0]            r_slot, n_slot;
    logic                  r_det, n_det;
    logic [CW-1:0]         r_mcand, n_mcand;
    logic [W-1:0]          r_mplier, n_mplier;
    logic [PW-1:0]         r_prod, n_prod;
    logic                  r_neg, n_neg;
    logic [MCW-1:0]        r_cnt, n_cnt;
    logic signed [DW-1:0]  r_acc, n_acc;
    logic                  r_sing, n_sing;
    logic                  r_dneg, n_dneg;
    logic [DW-1:0]         r_dmag, n_dmag;
    logic                  r_out_valid, n_out_valid;
    logic [W-1:0]          r_out_elem, n_out_elem;
    logic                  r_out_sat, n_out_sat;

    logic [W-1:0]          r_mat [16];
    logic [CW-1:0]         r_cof [16];
    logic [W-1:0]          r_mat_rd;
    logic [CW-1:0]         r_cof_rd;

    logic [3:0]            w_mat_addr;
    logic [3:0]            w_cof_addr;
    logic [W-1:0]          w_mag_e;
    logic [CW-1:0]         w_mag_c;
    logic [CW-1:0]         w_cof_wr;
    logic                  w_sub;
    logic                  w_div_start;
    logic [W-1:0]          w_div_value;
    t_div_sts              w_div_sts;

    assign w_mat_addr = r_det ? r_k
                              : f_minor_addr(r_k[3:2], r_k[1:0], f_term_pos(r_term, r_slot));
    // results run row-major, so the adjugate reads the cofactor transposed
    assign w_cof_addr = (r_state == ST_DFETCH) ? {r_k[1:0], r_k[3:2]} : r_k;
    assign w_mag_e    = r_mat_rd[W-1] ? (~r_mat_rd + W'(1)) : r_mat_rd;
    assign w_mag_c    = r_cof_rd[CW-1] ? (~r_cof_rd + CW'(1)) : r_cof_rd;
    assign w_cof_wr   = (r_k[2] ^ r_k[0]) ? CW'(-r_acc) : r_acc[CW-1:0];
    assign w_sub      = r_det ? r_neg : (r_neg ^ (r_term >= NEG_TERM_FIRST));
    assign w_div_start = (r_state == ST_DLOAD) && !r_sing;

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LOAD) && i_elem.valid) begin
            r_mat[r_k] <= i_elem.element;
        end
        r_mat_rd <= r_mat[w_mat_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CWR) begin
            r_cof[r_k] <= w_cof_wr;
        end
        r_cof_rd <= r_cof[w_cof_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_term      = r_term;
        n_slot      = r_slot;
        n_det       = r_det;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_sing      = r_sing;
        n_dneg      = r_dneg;
        n_dmag      = r_dmag;
        n_out_valid = r_out_valid;
        n_out_elem  = r_out_elem;
        n_out_sat   = r_out_sat;
        unique case (r_state)
            ST_LOAD: begin
                if (i_elem.valid) begin
                    n_k = r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        n_state = ST_FETCH;
                        n_k     = 4'd0;
                        n_term  = 3'd0;
                        n_slot  = 2'd0;
                        n_det   = 1'b0;
                        n_acc   = '0;
                    end
                end
            end
            ST_FETCH: n_state = ST_USE;
            ST_USE: begin
                unique case (r_slot)
                    2'd0: begin
                        n_mcand = CW'(w_mag_e);
                        n_neg   = r_mat_rd[W-1];
                        n_slot  = 2'd1;
                        n_state = ST_FETCH;
                    end
                    2'd1: begin
                        n_mplier = w_mag_e;
                        n_neg    = r_neg ^ r_mat_rd[W-1];
                        n_prod   = '0;
                        n_cnt    = MCW'(W - 1);
                        n_state  = ST_MUL;
                    end
                    default: begin
                        n_mcand  = r_prod[CW-1:0];
                        n_mplier = w_mag_e;
                        n_neg    = r_neg ^ r_mat_rd[W-1];
                        n_prod   = '0;
                        n_cnt    = MCW'(W - 1);
                        n_state  = ST_MUL;
                    end
                endcase
            end
            ST_MUL: begin
                n_prod   = (r_prod << 1) + (r_mplier[W-1] ? PW'(r_mcand) : '0);
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt - MCW'(1);
                if (r_cnt == '0) begin
                    if (!r_det && (r_slot == 2'd1)) begin
                        n_slot  = 2'd2;
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                n_acc = w_sub ? (r_acc - DW'(r_prod)) : (r_acc + DW'(r_prod));
                if (r_det) begin
                    if (r_k == 4'd3) begin
                        n_state = ST_DSETUP;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = ST_CFETCH;
                    end
                end else if (r_term == LAST_TERM) begin
                    n_state = ST_CWR;
                end else begin
                    n_term  = r_term + 3'd1;
                    n_slot  = 2'd0;
                    n_state = ST_FETCH;
                end
            end
            ST_CWR: begin
                n_acc  = '0;
                n_term = 3'd0;
                n_slot = 2'd0;
                if (r_k == 4'd15) begin
                    n_det   = 1'b1;
                    n_k     = 4'd0;
                    n_state = ST_CFETCH;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = ST_FETCH;
                end
            end
            ST_CFETCH: n_state = ST_CUSE;
            ST_CUSE: begin
                n_mcand = w_mag_c;
                n_neg   = r_cof_rd[CW-1];
                n_slot  = 2'd1;
                n_state = ST_FETCH;
            end
            ST_DSETUP: begin
                n_sing  = (r_acc == '0);
                n_dneg  = r_acc[DW-1];
                n_dmag  = r_acc[DW-1] ? DW'(-r_acc) : DW'(r_acc);
                n_k     = 4'd0;
                n_state = ST_DFETCH;
            end
            ST_DFETCH: n_state = ST_DLOAD;
            ST_DLOAD: begin
                if (r_sing) begin
                    n_out_elem  = (r_k[3:2] == r_k[1:0]) ? ONE_VAL : '0;
                    n_out_sat   = (r_k[3:2] == r_k[1:0]) && ONE_SAT;
                    n_out_valid = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_sts.done) begin
                    n_out_elem  = w_div_value;
                    n_out_sat   = w_div_sts.sat;
                    n_out_valid = 1'b1;
                    n_state     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (o_res.ready) begin
                    n_out_valid = 1'b0;
                    if (r_k == 4'd15) begin
                        n_k     = 4'd0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = ST_DFETCH;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_k         <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_term     <= n_term;
        r_slot     <= n_slot;
        r_det      <= n_det;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_sing     <= n_sing;
        r_dneg     <= n_dneg;
        r_dmag     <= n_dmag;
        r_out_elem <= n_out_elem;
        r_out_sat  <= n_out_sat;
    end

    m4inv_div #(
        .ELEMENT_WIDTH (W),
        .NUM_W         (NW),
        .DEN_W         (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_neg   (r_cof_rd[CW-1] ^ r_dneg),
        .i_num   (NW'(w_mag_c) << (2 * F)),
        .i_dmag  (r_dmag),
        .o_value (w_div_value),
        .o_sts   (w_div_sts)
    );

    assign i_elem.ready         = (r_state == ST_LOAD);
    assign o_res.valid          = r_out_valid;
    assign o_res.result_element = r_out_elem;
    assign o_res.result_index   = r_k;
    assign o_res.final_res      = (r_k == 4'd15);
    assign o_res.singular       = r_sing;
    assign o_res.saturated      = r_out_sat;

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_OUT))
        else $error("result valid outside output state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_elem.ready |-> !o_res.valid)
        else $error("loading while a result is pending");

    a_last_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.final_res) |=> i_elem.ready)
        else $error("no return to loading after last transfer");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the 4x4 fixed-point cofactor matrix inverse.
module testbench;
    import m4inv_pkg::*;

    localparam int W  = ELEMENT_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic signed [W-1:0] EL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] EL_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q  = W'(1) <<< FB;
    localparam int HOLD_CYCLES = 25000;

    typedef logic signed [255:0] t_big;

    typedef struct {
        logic signed [W-1:0] value;
        logic [3:0]          index;
        logic                last;
        logic                sing;
        logic                sat;
    } t_inv_elem;

    // keeps a copy of the loaded matrix and the inverse elements still owed
    class inverse_scoreboard;
        logic signed [W-1:0] mat [16];
        int                  loaded;
        t_inv_elem           owed [$];
        int                  errors;
        int                  matrices;
        int                  singular_seen;
        int                  sat_seen;

        function new();
            loaded = 0;
            errors = 0;
            matrices = 0;
            singular_seen = 0;
            sat_seen = 0;
        endfunction

        function t_big cofactor(int r, int c);
            t_big m [9];
            t_big acc;
            int   k;
            k = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    if (i != r && j != c) begin
                        m[k] = t_big'(mat[i*4+j]);
                        k++;
                    end
            acc = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
                - m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
            if ((r + c) % 2 == 1) acc = -acc;
            return acc;
        endfunction

        function void note_element(logic signed [W-1:0] v);
            t_big      cof [16];
            t_big      det;
            t_big      q;
            t_inv_elem e;
            mat[loaded] = v;
            loaded++;
            if (loaded < 16) return;
            loaded = 0;
            matrices++;
            det = '0;
            for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
            for (int k = 0; k < 4; k++) det = det + t_big'(mat[k]) * cof[k];
            if (det == 0) singular_seen++;
            for (int k = 0; k < 16; k++) begin
                e.index = 4'(k);
                e.last  = (k == 15);
                e.sing  = (det == 0);
                e.sat   = 1'b0;
                if (det == 0) begin
                    e.value = (k / 4 == k % 4) ? ONE_Q : '0;
                end else begin
                    // truncating signed division rounds toward zero
                    q = (cof[(k % 4) * 4 + k / 4] <<< (2 * FB)) / det;
                    if (q > t_big'(EL_MAX)) begin
                        e.value = EL_MAX;
                        e.sat   = 1'b1;
                    end else if (q < t_big'(EL_MIN)) begin
                        e.value = EL_MIN;
                        e.sat   = 1'b1;
                    end else begin
                        e.value = q[W-1:0];
                    end
                end
                if (e.sat) sat_seen++;
                owed.insert(owed.size(), e);
            end
        endfunction

        function void check_result(logic signed [W-1:0] v, logic [3:0] idx, logic last,
                                   logic sing, logic sat);
            t_inv_elem e;
            if (owed.size() == 0) begin
                $error("unexpected result transfer: element %0d index %0d", v, idx);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (v !== e.value) begin
                $error("result_element: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (idx !== e.index) begin
                $error("result_index: expected %0d, got %0d", e.index, idx);
                errors++;
            end
            if (last !== e.last) begin
                $error("final_res: expected %0b, got %0b", e.last, last);
                errors++;
            end
            if (sing !== e.sing) begin
                $error("singular: expected %0b, got %0b", e.sing, sing);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, got %0b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    m4inv_in_if  #(.ELEMENT_WIDTH(W)) elem_ch ();
    m4inv_out_if #(.ELEMENT_WIDTH(W)) res_ch ();

    matrix4_inverse_by_cofactors_top #(
        .FRAC_BITS     (FB),
        .ELEMENT_WIDTH (W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch.sink),
        .o_res   (res_ch.source)
    );

    inverse_scoreboard sb = new();

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off        = 0;
    bit long_hold_req   = 1'b0;
    bit long_hold_taken = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver: random stalls plus one long hold-off, counted here
    always @(posedge i_clk) begin
        if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_off        <= HOLD_CYCLES;
            res_ch.ready    <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && elem_ch.valid && elem_ch.ready) sb.note_element(elem_ch.element);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.result_element, res_ch.result_index, res_ch.final_res,
                            res_ch.singular, res_ch.saturated);
    end

    task automatic send_element(logic signed [W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_ch.valid   <= 1'b1;
        elem_ch.element <= v;
        do @(posedge i_clk); while (!elem_ch.ready);
    endtask

    task automatic send_matrix(logic signed [W-1:0] m [16]);
        for (int k = 0; k < 16; k++) send_element(m[k]);
    endtask

    function automatic logic signed [W-1:0] rand_element();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return W'($signed($urandom_range(8 << FB)) - (4 <<< FB));
            2:       return W'($signed($urandom_range(255)) - 128);
            3:       return $urandom_range(1) ? EL_MAX - $urandom_range(3)
                                              : EL_MIN + $urandom_range(3);
            default: return W'($signed($urandom_range(1 << FB)) - (1 <<< (FB - 1)));
        endcase
    endfunction

    // stop offering, let the monitor see the last transfer, then wait for all results
    task automatic wait_drained();
        elem_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [W-1:0] m [16];
        elem_ch.valid   = 1'b0;
        elem_ch.element = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero matrix gives identity, identity inverts to itself
        foreach (m[k]) m[k] = '0;
        send_matrix(m);
        foreach (m[k]) m[k] = (k % 5 == 0) ? ONE_Q : '0;
        send_matrix(m);
        // extreme diagonal and off-diagonal terms, tiny entries saturate on inversion
        foreach (m[k]) m[k] = '0;
        m[0] = EL_MAX; m[5] = EL_MIN; m[10] = 1; m[15] = -1; m[3] = EL_MIN; m[12] = -2;
        send_matrix(m);
        wait_drained();

        for (int mi = 0; mi < 7; mi++) begin
            case (mi % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (mi == 4) long_hold_req = 1'b1;
            foreach (m[k]) m[k] = rand_element();
            // some well-conditioned and some rank-deficient matrices
            if ($urandom_range(2) == 0)
                for (int d = 0; d < 4; d++) m[d*5] = W'($signed($urandom_range(16)) + 2) <<< FB;
            if (mi == 6) for (int c = 0; c < 4; c++) m[8+c] = m[c];
            send_matrix(m);
            if (mi == 2) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Ran %0d matrices (%0d singular), %0d saturated inverse elements.",
                 sb.matrices, sb.singular_seen, sb.sat_seen);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
